>>> rtl/swse_pkg.sv
package swse_pkg;

    // field widths of the stream words
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 32;
    localparam int SLOPE_W  = 32;
    localparam int STATUS_W = 2;

    // quotient bits produced by the divider
    localparam int QUO_W = 32;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOPE_W-1:0]  slope_t;

    // result status codes
    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_FEW  = 2'd1;
    localparam status_t STATUS_FLAT = 2'd2;
    localparam status_t STATUS_SAT  = 2'd3;

    // saturation bounds
    localparam slope_t SLOPE_MAX = 32'h7FFF_FFFF;
    localparam slope_t SLOPE_MIN = 32'h8000_0000;

endpackage

>>> rtl/sliding_window_slope_estimator.sv
// Fewer than two stored samples, a flat window or a quotient over 32 bits skip the divider
// and give a status word; the scale step walks the CNT_W = $clog2(WINDOW+1) bits of n.
// One shared 36x36 multiplier for the scan, then a radix-2 divider, one quotient bit per cycle.
// tready only while idle: no new sample is taken until the last one's output word is issued.
// Reset: async active low; ring empty, write slot 0, no output word pending.
module sliding_window_slope_estimator
    import swse_pkg::*;
#(
    parameter int WINDOW = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] sample_time, [63:32] sample_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] slope
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SCL_W  = $clog2(CNT_W);
    localparam int DIF_W  = TIME_W + 1;
    localparam int MUL_W  = DIF_W + IDX_W;
    localparam int WIDE_W = 2 * MUL_W;
    localparam int DCNT_W = $clog2(QUO_W);

    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW);
    localparam logic [SCL_W-1:0]  SCL_LAST = SCL_W'(CNT_W - 1);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(QUO_W - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BASE  = 4'd1;
    localparam logic [3:0] S_ORIG  = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_MTS   = 4'd4;
    localparam logic [3:0] S_MTT   = 4'd5;
    localparam logic [3:0] S_ACCD  = 4'd6;
    localparam logic [3:0] S_SCALE = 4'd7;
    localparam logic [3:0] S_MBC   = 4'd8;
    localparam logic [3:0] S_MBB   = 4'd9;
    localparam logic [3:0] S_DEN   = 4'd10;
    localparam logic [3:0] S_CHK   = 4'd11;
    localparam logic [3:0] S_OVF   = 4'd12;
    localparam logic [3:0] S_DIV   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    // sample ring
    logic [TIME_W-1:0]  time_mem  [WINDOW];
    logic [LEVEL_W-1:0] level_mem [WINDOW];

    // control registers
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  wslot_reg, wslot_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [SCL_W-1:0]  bit_reg, bit_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    // datapath registers
    logic [TIME_W-1:0]  rd_time_reg;
    logic [LEVEL_W-1:0] rd_level_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [TIME_W-1:0]  t0_reg, t0_next;
    logic [LEVEL_W-1:0] l0_reg, l0_next;
    logic [DIF_W-1:0]   t_reg, t_next;
    logic [DIF_W-1:0]   s_reg, s_next;
    logic [MUL_W-1:0]   bsum_reg, bsum_next;
    logic [MUL_W-1:0]   csum_reg, csum_next;
    logic [WIDE_W-1:0]  asum_reg, asum_next;
    logic [WIDE_W-1:0]  dsum_reg, dsum_next;
    logic [WIDE_W-1:0]  num_reg, num_next;
    logic [WIDE_W-1:0]  den_reg, den_next;
    logic [WIDE_W-1:0]  prod_reg;
    logic [WIDE_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               neg_reg, neg_next;
    slope_t             res_slope_reg, res_slope_next;
    status_t            res_status_reg, res_status_next;
    slope_t             out_slope_reg, out_slope_next;
    status_t            out_status_reg, out_status_next;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [WIDE_W-1:0] mul_p;

    // combinational helpers
    logic              store_en;
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W:0]   div_sh, div_diff;
    logic [IDX_W-1:0]  idx_inc;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign store_en      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_slope_reg;
    assign m_axis_tuser  = out_status_reg;

    assign idx_inc  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign mag      = num_reg[WIDE_W-1] ? (~num_reg + 1'b1) : num_reg;
    assign div_sh   = {rem_reg, quo_reg[QUO_W-1]};
    assign div_diff = div_sh - {1'b0, den_reg};

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MTS:
            begin
                mul_a = {{IDX_W{t_reg[DIF_W-1]}}, t_reg};
                mul_b = {{IDX_W{s_reg[DIF_W-1]}}, s_reg};
            end
            S_MTT:
            begin
                mul_a = {{IDX_W{t_reg[DIF_W-1]}}, t_reg};
                mul_b = {{IDX_W{t_reg[DIF_W-1]}}, t_reg};
            end
            S_MBC:
            begin
                mul_a = bsum_reg;
                mul_b = csum_reg;
            end
            S_MBB:
            begin
                mul_a = bsum_reg;
                mul_b = bsum_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        wslot_next      = wslot_reg;
        idx_next        = idx_reg;
        left_next       = left_reg;
        bit_next        = bit_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        n_next          = n_reg;
        t0_next         = t0_reg;
        l0_next         = l0_reg;
        t_next          = t_reg;
        s_next          = s_reg;
        bsum_next       = bsum_reg;
        csum_next       = csum_reg;
        asum_next       = asum_reg;
        dsum_next       = dsum_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        neg_next        = neg_reg;
        res_slope_next  = res_slope_reg;
        res_status_next = res_status_reg;
        out_slope_next  = out_slope_reg;
        out_status_next = out_status_reg;

        // output word leaves
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    wslot_next = (wslot_reg == IDX_LAST) ? '0 : wslot_reg + 1'b1;
                    fill_next  = (fill_reg == WIN_CNT) ? fill_reg : fill_reg + 1'b1;
                    n_next     = fill_next;
                    left_next  = fill_next - 1'b1;
                    // oldest entry: slot 0 until the ring is full, then the next slot
                    idx_next   = (fill_reg == WIN_CNT) ? wslot_next : '0;
                    bsum_next  = '0;
                    csum_next  = '0;
                    asum_next  = '0;
                    dsum_next  = '0;
                    num_next   = '0;
                    den_next   = '0;
                    bit_next   = '0;
                    if (fill_next < CNT_W'(2))
                    begin
                        res_slope_next  = '0;
                        res_status_next = STATUS_FEW;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE:
            begin
                idx_next   = idx_inc;
                state_next = S_ORIG;
            end
            S_ORIG:
            begin
                t0_next    = rd_time_reg;
                l0_next    = rd_level_reg;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                // offsets from the oldest sample
                t_next     = {1'b0, rd_time_reg - t0_reg};
                s_next     = {rd_level_reg[LEVEL_W-1], rd_level_reg}
                           - {l0_reg[LEVEL_W-1], l0_reg};
                idx_next   = idx_inc;
                state_next = S_MTS;
            end
            S_MTS:
            begin
                bsum_next  = bsum_reg + {{IDX_W{1'b0}}, t_reg};
                csum_next  = csum_reg + {{IDX_W{s_reg[DIF_W-1]}}, s_reg};
                state_next = S_MTT;
            end
            S_MTT:
            begin
                asum_next  = asum_reg + prod_reg;
                state_next = S_ACCD;
            end
            S_ACCD:
            begin
                dsum_next = dsum_reg + prod_reg;
                if (left_reg == CNT_W'(1))
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    left_next  = left_reg - 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_SCALE:
            begin
                // n*A and n*D by shift and add, one bit of n per cycle
                if (n_reg[bit_reg])
                begin
                    num_next = num_reg + (asum_reg << bit_reg);
                    den_next = den_reg + (dsum_reg << bit_reg);
                end
                if (bit_reg == SCL_LAST)
                begin
                    state_next = S_MBC;
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end
            S_MBC:
            begin
                state_next = S_MBB;
            end
            S_MBB:
            begin
                num_next   = num_reg - prod_reg;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                den_next   = den_reg - prod_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (den_reg == '0)
                begin
                    res_slope_next  = '0;
                    res_status_next = STATUS_FLAT;
                    state_next      = S_DONE;
                end
                else
                begin
                    neg_next   = num_reg[WIDE_W-1];
                    rem_next   = {{QUO_W{1'b0}}, mag[WIDE_W-1:QUO_W]};
                    quo_next   = mag[QUO_W-1:0];
                    state_next = S_OVF;
                end
            end
            S_OVF:
            begin
                // upper part not below the divisor: quotient needs more than 32 bits
                if (rem_reg >= den_reg)
                begin
                    res_slope_next  = neg_reg ? SLOPE_MIN : SLOPE_MAX;
                    res_status_next = STATUS_SAT;
                    state_next      = S_DONE;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring step
                if (div_diff[WIDE_W])
                begin
                    rem_next = div_sh[WIDE_W-1:0];
                end
                else
                begin
                    rem_next = div_diff[WIDE_W-1:0];
                end
                quo_next = {quo_reg[QUO_W-2:0], ~div_diff[WIDE_W]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (neg_reg ? (quo_reg > SLOPE_MIN) : (quo_reg > SLOPE_MAX))
                begin
                    res_slope_next  = neg_reg ? SLOPE_MIN : SLOPE_MAX;
                    res_status_next = STATUS_SAT;
                end
                else
                begin
                    res_slope_next  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                    res_status_next = STATUS_OK;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_slope_next  = res_slope_reg;
                    out_status_next = res_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            wslot_reg     <= '0;
            idx_reg       <= '0;
            left_reg      <= '0;
            bit_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            wslot_reg     <= wslot_next;
            idx_reg       <= idx_next;
            left_reg      <= left_next;
            bit_reg       <= bit_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        t0_reg         <= t0_next;
        l0_reg         <= l0_next;
        t_reg          <= t_next;
        s_reg          <= s_next;
        bsum_reg       <= bsum_next;
        csum_reg       <= csum_next;
        asum_reg       <= asum_next;
        dsum_reg       <= dsum_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        prod_reg       <= mul_p;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        neg_reg        <= neg_next;
        res_slope_reg  <= res_slope_next;
        res_status_reg <= res_status_next;
        out_slope_reg  <= out_slope_next;
        out_status_reg <= out_status_next;
    end

    // sample ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            time_mem[wslot_reg]  <= s_axis_tdata[TIME_W-1:0];
            level_mem[wslot_reg] <= s_axis_tdata[TIME_W+LEVEL_W-1:TIME_W];
        end
        rd_time_reg  <= time_mem[idx_reg];
        rd_level_reg <= level_mem[idx_reg];
    end

    // checks
    a_zero_slope: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_FEW || m_axis_tuser == STATUS_FLAT))
        |-> (m_axis_tdata == '0))
        else $error("slope not zero for a few-samples or flat word");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_SAT)
        |-> (m_axis_tdata == SLOPE_MAX || m_axis_tdata == SLOPE_MIN))
        else $error("saturated word is not a bound");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count moved by other than one");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

endmodule
